// File: design/ifdv_pkg.sv
// ----------------------------------------------------------------------------
// ifdv_pkg - shared types and constants for the IR frame dim/vignette core
// Register indexes, fixed-point constants, and the controller/datapath link.
// ----------------------------------------------------------------------------
package ifdv_pkg;

  // default for the largest supported frame dimension
  localparam int MAX_DIM_DEFAULT = 4096;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIGNETTE_GAIN = 2'd3;

  // field widths
  localparam int DIM_W  = 13;
  localparam int GAIN_W = 23;
  localparam int PIX_W  = 8;

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 23'd20;

  // pixel_format codes
  localparam logic FMT_RGB  = 1'b0;
  localparam logic FMT_GRAY = 1'b1;

  // Q16 luma weights (sum to 65536) and the 0.4 dim factor
  localparam int LUMA_W = 24;
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;
  localparam int DIMQ_W = 15;
  localparam logic [DIMQ_W-1:0] DIM_Q16 = 15'd26214;
  localparam int GRAYP_W = PIX_W + DIMQ_W;

  // vignette factor 2^24 - gd, Q24, range 1..2^24
  localparam int Q24   = 24;
  localparam int VF_W  = Q24 + 1;
  localparam logic [VF_W-1:0] VF_ONE = 25'h1000000;

  // dim = luma * 0.4 is Q32 and 39 bits; it is split for the final multiply
  localparam int P1_W    = LUMA_W + DIMQ_W;
  localparam int SPLIT   = 20;
  localparam int P1HI_W  = P1_W - SPLIT;
  localparam int PLO_W   = SPLIT + VF_W;
  localparam int PHI_W   = P1HI_W + VF_W;
  localparam int FIN_SH  = 56 - SPLIT;

  // shared multiplier operand width
  localparam int MUL_W = 32;

  // datapath steps issued by the controller
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_SQX  = 4'd1,
    OP_SQY  = 4'd2,
    OP_SUM  = 4'd3,
    OP_GAIN = 4'd4,
    OP_DIM  = 4'd5,
    OP_LO   = 4'd6,
    OP_HI   = 4'd7,
    OP_FIN  = 4'd8
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic gray;
    logic out_free;
  } sts_t;

endpackage

// File: design/ir_frame_dim_vignette_core.sv
// ----------------------------------------------------------------------------
// ir_frame_dim_vignette_core - dimmed, vignetted IR-style gray from camera
// Top level: sequencer plus datapath with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (red_or_gray, green, blue) arrive in raster order on the
//   in_valid/in_ready channel; one result word (ir_pixel, end_of_frame)
//   leaves on out_valid/out_ready for each input word.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while idle; the block does not enforce it.
// Steps:
//   RGB words run six multiply steps, a sum and a final step on the shared
//   multiplier; gray words skip the vignette and go to the final step.
//   The next word is taken only once the last is in the output register.
// Reset (rst, synchronous): registers go to 640x480, RGB, gain 20; the
//   column and row counters clear; no output word is pending.
// Stall: the result sits in an output register; the next word is taken
//   while it waits, and its finished result holds in the datapath until
//   the output register is free.
// ----------------------------------------------------------------------------
module ir_frame_dim_vignette_core #(
  parameter int MAX_DIMENSION = ifdv_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ifdv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifdv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ifdv_pkg::PIX_W-1:0]      red_or_gray,
  input  logic [ifdv_pkg::PIX_W-1:0]      green,
  input  logic [ifdv_pkg::PIX_W-1:0]      blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ifdv_pkg::PIX_W-1:0]      ir_pixel,
  output logic                            end_of_frame
);

  ifdv_pkg::cmd_t cmd;
  ifdv_pkg::sts_t sts;

  ifdv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ifdv_dp #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red_or_gray  (red_or_gray),
    .green        (green),
    .blue         (blue),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .ir_pixel     (ir_pixel),
    .end_of_frame (end_of_frame)
  );

endmodule

// File: design/ifdv_ctrl.sv
// ----------------------------------------------------------------------------
// ifdv_ctrl - sequencer for the IR frame dim/vignette core
// Walks one word through the shared-multiplier steps of the datapath.
// ----------------------------------------------------------------------------
module ifdv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ifdv_pkg::sts_t  sts,
  output ifdv_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQX  = 9'b000000010,
    S_SQY  = 9'b000000100,
    S_SUM  = 9'b000001000,
    S_GAIN = 9'b000010000,
    S_DIM  = 9'b000100000,
    S_LO   = 9'b001000000,
    S_HI   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = ifdv_pkg::OP_NONE;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          // gray words need no vignette
          state_next  = sts.gray ? S_FIN : S_SQX;
        end
      end
      S_SQX: begin
        cmd.op     = ifdv_pkg::OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = ifdv_pkg::OP_SQY;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = ifdv_pkg::OP_SUM;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.op     = ifdv_pkg::OP_GAIN;
        state_next = S_DIM;
      end
      S_DIM: begin
        cmd.op     = ifdv_pkg::OP_DIM;
        state_next = S_LO;
      end
      S_LO: begin
        cmd.op     = ifdv_pkg::OP_LO;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.op     = ifdv_pkg::OP_HI;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = ifdv_pkg::OP_FIN;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/ifdv_dp.sv
// ----------------------------------------------------------------------------
// ifdv_dp - datapath of the IR frame dim/vignette core
// Config registers, position counters, shared multiplier and output register.
// ----------------------------------------------------------------------------
module ifdv_dp #(
  parameter int MAX_DIMENSION = ifdv_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ifdv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifdv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ifdv_pkg::PIX_W-1:0]      red_or_gray,
  input  logic [ifdv_pkg::PIX_W-1:0]      green,
  input  logic [ifdv_pkg::PIX_W-1:0]      blue,
  input  ifdv_pkg::cmd_t                  cmd,
  output ifdv_pkg::sts_t                  sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ifdv_pkg::PIX_W-1:0]      ir_pixel,
  output logic                            end_of_frame
);

  localparam int CNT_W   = $clog2(MAX_DIMENSION);
  localparam int CMP_W   = (CNT_W + 1 > ifdv_pkg::DIM_W) ? CNT_W + 1 : ifdv_pkg::DIM_W;
  localparam int OFS_W   = CMP_W;
  localparam int SQ_W    = 2 * OFS_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int GD_W    = ifdv_pkg::GAIN_W + SUM_W;
  localparam int PROD_W  = (GD_W > ifdv_pkg::PLO_W) ? GD_W : ifdv_pkg::PLO_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIMENSION - 1);

  // configuration
  logic [ifdv_pkg::DIM_W-1:0]  frame_width;
  logic [ifdv_pkg::DIM_W-1:0]  frame_height;
  logic                        pixel_format;
  logic [ifdv_pkg::GAIN_W-1:0] vignette_gain;

  // position
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic             row_end;
  logic             frame_end;

  // captured word
  logic                        gray_q;
  logic                        eof_q;
  logic [ifdv_pkg::LUMA_W-1:0] luma_q;
  logic [OFS_W-1:0]            ox_q;
  logic [OFS_W-1:0]            oy_q;
  logic [ifdv_pkg::PIX_W-1:0]  gray_pix_q;

  // arithmetic
  logic [ifdv_pkg::LUMA_W-1:0]  luma_c;
  logic [ifdv_pkg::GRAYP_W-1:0] gray_prod;
  logic [OFS_W-1:0]             two_x;
  logic [OFS_W-1:0]             two_y;
  logic [OFS_W-1:0]             w_ext;
  logic [OFS_W-1:0]             h_ext;
  logic [OFS_W-1:0]             ox_c;
  logic [OFS_W-1:0]             oy_c;
  logic [ifdv_pkg::MUL_W-1:0]   mul_a;
  logic [ifdv_pkg::MUL_W-1:0]   mul_b;
  logic [2*ifdv_pkg::MUL_W-1:0] mul_p;
  logic [PROD_W-1:0]            prod;
  logic [SQ_W-1:0]              sqx_q;
  logic [SUM_W-1:0]             dsum;
  logic                         kill_q;
  logic [ifdv_pkg::VF_W-1:0]    vfac;
  logic [ifdv_pkg::P1HI_W-1:0]  p1hi;
  logic [ifdv_pkg::PLO_W-1:0]   plo_q;
  logic [ifdv_pkg::PLO_W-1:0]   fin_sum;
  logic [ifdv_pkg::PIX_W-1:0]   rgb_pix;
  logic                         load_out;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= ifdv_pkg::WIDTH_RST;
      frame_height  <= ifdv_pkg::HEIGHT_RST;
      pixel_format  <= ifdv_pkg::FMT_RGB;
      vignette_gain <= ifdv_pkg::GAIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ifdv_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data[ifdv_pkg::DIM_W-1:0];
        ifdv_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data[ifdv_pkg::DIM_W-1:0];
        ifdv_pkg::REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[0];
        ifdv_pkg::REG_VIGNETTE_GAIN: vignette_gain <= cfg_data;
      endcase
    end
  end

  // counters never pass MAX_DIMENSION-1: a row or frame ends there; a zero size acts as one
  always_comb begin
    row_end   = (CMP_W'(column_count) + CMP_W'(1) >= CMP_W'(frame_width)) ||
                (column_count == CNT_LAST);
    frame_end = row_end &&
                ((CMP_W'(row_count) + CMP_W'(1) >= CMP_W'(frame_height)) ||
                 (row_count == CNT_LAST));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.capture) begin
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (row_end) begin
        column_count <= '0;
        row_count    <= row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

  // per-word front end: luma, gray result, radial offsets
  always_comb begin
    luma_c = ifdv_pkg::LUMA_W'(red_or_gray) * ifdv_pkg::LUMA_W'(ifdv_pkg::LUMA_R) +
             ifdv_pkg::LUMA_W'(green)       * ifdv_pkg::LUMA_W'(ifdv_pkg::LUMA_G) +
             ifdv_pkg::LUMA_W'(blue)        * ifdv_pkg::LUMA_W'(ifdv_pkg::LUMA_B);
    gray_prod = ifdv_pkg::GRAYP_W'(red_or_gray) * ifdv_pkg::GRAYP_W'(ifdv_pkg::DIM_Q16);
    two_x = OFS_W'({column_count, 1'b0});
    two_y = OFS_W'({row_count, 1'b0});
    w_ext = OFS_W'(frame_width);
    h_ext = OFS_W'(frame_height);
    ox_c  = (two_x >= w_ext) ? two_x - w_ext : w_ext - two_x;
    oy_c  = (two_y >= h_ext) ? two_y - h_ext : h_ext - two_y;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gray_q     <= pixel_format;
      eof_q      <= frame_end;
      luma_q     <= luma_c;
      ox_q       <= ox_c;
      oy_q       <= oy_c;
      // 255 * 0.4 stays below 256, so no clamp is needed
      gray_pix_q <= {1'b0, gray_prod[ifdv_pkg::GRAYP_W-1:16]};
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      ifdv_pkg::OP_SQX: begin
        mul_a = ifdv_pkg::MUL_W'(ox_q);
        mul_b = ifdv_pkg::MUL_W'(ox_q);
      end
      ifdv_pkg::OP_SQY: begin
        mul_a = ifdv_pkg::MUL_W'(oy_q);
        mul_b = ifdv_pkg::MUL_W'(oy_q);
      end
      ifdv_pkg::OP_GAIN: begin
        mul_a = ifdv_pkg::MUL_W'(vignette_gain);
        mul_b = ifdv_pkg::MUL_W'(dsum);
      end
      ifdv_pkg::OP_DIM: begin
        mul_a = ifdv_pkg::MUL_W'(luma_q);
        mul_b = ifdv_pkg::MUL_W'(ifdv_pkg::DIM_Q16);
      end
      ifdv_pkg::OP_LO: begin
        mul_a = ifdv_pkg::MUL_W'(prod[ifdv_pkg::SPLIT-1:0]);
        mul_b = ifdv_pkg::MUL_W'(vfac);
      end
      ifdv_pkg::OP_HI: begin
        mul_a = ifdv_pkg::MUL_W'(p1hi);
        mul_b = ifdv_pkg::MUL_W'(vfac);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ifdv_pkg::OP_SQX: begin
        prod <= mul_p[PROD_W-1:0];
      end
      ifdv_pkg::OP_SQY: begin
        prod  <= mul_p[PROD_W-1:0];
        sqx_q <= prod[SQ_W-1:0];
      end
      ifdv_pkg::OP_SUM: begin
        dsum <= SUM_W'(sqx_q) + SUM_W'(prod[SQ_W-1:0]);
      end
      ifdv_pkg::OP_GAIN: begin
        prod <= mul_p[PROD_W-1:0];
      end
      ifdv_pkg::OP_DIM: begin
        // prod holds gain*d here; at or past one the vignette zeroes the word
        prod   <= mul_p[PROD_W-1:0];
        kill_q <= |prod[GD_W-1:ifdv_pkg::Q24];
        vfac   <= ifdv_pkg::VF_ONE - ifdv_pkg::VF_W'(prod[ifdv_pkg::Q24-1:0]);
      end
      ifdv_pkg::OP_LO: begin
        prod <= mul_p[PROD_W-1:0];
        p1hi <= prod[ifdv_pkg::P1_W-1:ifdv_pkg::SPLIT];
      end
      ifdv_pkg::OP_HI: begin
        prod  <= mul_p[PROD_W-1:0];
        plo_q <= prod[ifdv_pkg::PLO_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // (hi*v << 20 + lo*v) >> 56 == (hi*v + (lo*v >> 20)) >> 36; result < 102
  always_comb begin
    fin_sum = ifdv_pkg::PLO_W'(prod[ifdv_pkg::PHI_W-1:0]) +
              ifdv_pkg::PLO_W'(plo_q[ifdv_pkg::PLO_W-1:ifdv_pkg::SPLIT]);
    rgb_pix = kill_q ? '0 :
              fin_sum[ifdv_pkg::FIN_SH+ifdv_pkg::PIX_W-1:ifdv_pkg::FIN_SH];
  end

  // output register
  assign sts.out_free = !out_valid || out_ready;
  assign sts.gray     = pixel_format;
  assign load_out     = (cmd.op == ifdv_pkg::OP_FIN) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ir_pixel     <= gray_q ? gray_pix_q : rgb_pix;
      end_of_frame <= eof_q;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (column_count <= CNT_LAST) && (row_count <= CNT_LAST))
    else $error("position counter past the largest dimension");

  a_eof_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.capture && frame_end |=> (column_count == '0) && (row_count == '0))
    else $error("counters did not wrap at end of frame");

  a_kill_zero: assert property (@(posedge clk) disable iff (rst)
    load_out && !gray_q && kill_q |=> (ir_pixel == '0))
    else $error("vignette cutoff did not zero the word");

endmodule
